@@ rtl/fipc_pkg.sv @@
// ----------------------------------------------------------------------------
// fipc_pkg: fuel injection pulse calculator shared definitions
// Types, fixed-point constants, register codes and the two fuel maps.
// ----------------------------------------------------------------------------
`default_nettype none

package fipc_pkg;

   // Register indexes on the configuration port
   localparam logic [2:0] CSR_MAP_SELECT   = 3'd0;
   localparam logic [2:0] CSR_CLOSED_LOOP  = 3'd1;
   localparam logic [2:0] CSR_REV_LIMIT    = 3'd2;
   localparam logic [2:0] CSR_OVERRUN_CUT  = 3'd3;
   localparam logic [2:0] CSR_IDLE_THROTTLE = 3'd4;
   localparam logic [2:0] CSR_START_RPM    = 3'd5;
   localparam logic [2:0] CSR_STALL_RPM    = 3'd6;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 13;

   // Register reset values
   localparam logic [12:0] REV_LIMIT_RST     = 13'd6500;
   localparam logic [12:0] OVERRUN_CUT_RST   = 13'd1800;
   localparam logic [9:0]  IDLE_THROTTLE_RST = 10'd20;
   localparam logic [12:0] START_RPM_RST     = 13'd300;
   localparam logic [12:0] STALL_RPM_RST     = 13'd400;

   // Serial divider geometry
   localparam int DIV_NUM_W = 34;
   localparam int DIV_DEN_W = 18;
   localparam int DIV_Q_W   = 25;
   localparam int DIV_CNT_W = 6;

   // Lambda factor: ((102300 + 100*s) * 65536 + 75190) / 150381, Q1.16
   localparam logic [17:0] LAMBDA_BASE  = 18'd102300;
   localparam logic [6:0]  LAMBDA_SCALE = 7'd100;
   localparam logic [33:0] LAMBDA_RND   = 34'd75190;
   localparam logic [17:0] LAMBDA_DEN   = 18'd150381;
   localparam logic [5:0]  LAMBDA_STEPS = 6'd17;
   localparam logic [16:0] FACTOR_ONE   = 17'd65536;
   localparam logic [16:0] FACTOR_MIN   = 17'd50412;
   localparam logic [16:0] FACTOR_MAX   = 17'd93623;

   // Firing period: 18750000 / rpm
   localparam logic [24:0] PERIOD_CONST = 25'd18750000;
   localparam logic [5:0]  PERIOD_STEPS = 6'd25;

   // Pulse saturation: v > 255<<16, and with cranking 13*v >= 10*(255<<16)+10
   localparam logic [24:0] PULSE_SAT_V  = 25'd16711680;
   localparam logic [28:0] PULSE_SAT_X  = 29'd167116810;
   localparam logic [3:0]  CRANK_MUL    = 4'd13;
   localparam logic [12:0] DIV10_RECIP  = 13'd6554;
   localparam logic [7:0]  PULSE_MAX    = 8'd255;

   typedef struct packed {
      logic        map_select;
      logic        closed_loop;
      logic [12:0] rev_limit_rpm;
      logic [12:0] overrun_cut_rpm;
      logic [9:0]  idle_throttle_limit;
      logic [12:0] start_rpm;
      logic [12:0] stall_rpm;
   } fipc_cfg_type;

   typedef struct packed {
      logic                 load;
      logic [DIV_DEN_W-1:0] rem_init;
      logic [DIV_NUM_W-1:0] num;
      logic [DIV_DEN_W-1:0] den;
      logic [DIV_CNT_W-1:0] steps;
   } fipc_div_req_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_INDEX,
      S_LDL,
      S_LAMBDA,
      S_MUL,
      S_SCALE,
      S_PULSE,
      S_LDP,
      S_PERIOD,
      S_OUT
   } fipc_state_type;

   localparam logic [7:0] MAP_ECO [256] = '{
      8'd20, 8'd22, 8'd24, 8'd26, 8'd28, 8'd30, 8'd32, 8'd34,
      8'd36, 8'd38, 8'd40, 8'd42, 8'd44, 8'd46, 8'd48, 8'd50,
      8'd22, 8'd24, 8'd26, 8'd28, 8'd30, 8'd32, 8'd34, 8'd36,
      8'd38, 8'd40, 8'd42, 8'd44, 8'd46, 8'd48, 8'd50, 8'd52,
      8'd24, 8'd26, 8'd28, 8'd30, 8'd32, 8'd34, 8'd36, 8'd38,
      8'd40, 8'd42, 8'd44, 8'd46, 8'd48, 8'd50, 8'd52, 8'd55,
      8'd26, 8'd28, 8'd30, 8'd32, 8'd34, 8'd36, 8'd38, 8'd40,
      8'd42, 8'd44, 8'd46, 8'd48, 8'd50, 8'd52, 8'd55, 8'd58,
      8'd28, 8'd30, 8'd32, 8'd34, 8'd36, 8'd38, 8'd40, 8'd42,
      8'd44, 8'd46, 8'd48, 8'd50, 8'd52, 8'd55, 8'd58, 8'd61,
      8'd30, 8'd32, 8'd34, 8'd36, 8'd38, 8'd40, 8'd42, 8'd44,
      8'd46, 8'd48, 8'd50, 8'd52, 8'd55, 8'd58, 8'd61, 8'd65,
      8'd32, 8'd34, 8'd36, 8'd38, 8'd40, 8'd42, 8'd44, 8'd46,
      8'd48, 8'd50, 8'd52, 8'd55, 8'd58, 8'd61, 8'd65, 8'd70,
      8'd34, 8'd36, 8'd38, 8'd40, 8'd42, 8'd44, 8'd46, 8'd48,
      8'd50, 8'd52, 8'd55, 8'd58, 8'd61, 8'd65, 8'd70, 8'd75,
      8'd36, 8'd38, 8'd40, 8'd42, 8'd44, 8'd46, 8'd48, 8'd50,
      8'd52, 8'd55, 8'd58, 8'd61, 8'd65, 8'd70, 8'd75, 8'd80,
      8'd38, 8'd40, 8'd42, 8'd44, 8'd46, 8'd48, 8'd50, 8'd52,
      8'd55, 8'd58, 8'd61, 8'd65, 8'd70, 8'd75, 8'd80, 8'd85,
      8'd40, 8'd42, 8'd44, 8'd46, 8'd48, 8'd50, 8'd52, 8'd55,
      8'd58, 8'd61, 8'd65, 8'd70, 8'd75, 8'd80, 8'd85, 8'd90,
      8'd42, 8'd44, 8'd46, 8'd48, 8'd50, 8'd52, 8'd55, 8'd58,
      8'd61, 8'd65, 8'd70, 8'd75, 8'd80, 8'd85, 8'd90, 8'd95,
      8'd44, 8'd46, 8'd48, 8'd50, 8'd52, 8'd55, 8'd58, 8'd61,
      8'd65, 8'd70, 8'd75, 8'd80, 8'd85, 8'd90, 8'd95, 8'd100,
      8'd46, 8'd48, 8'd50, 8'd52, 8'd55, 8'd58, 8'd61, 8'd65,
      8'd70, 8'd75, 8'd80, 8'd85, 8'd90, 8'd95, 8'd100, 8'd105,
      8'd48, 8'd50, 8'd52, 8'd55, 8'd58, 8'd61, 8'd65, 8'd70,
      8'd75, 8'd80, 8'd85, 8'd90, 8'd95, 8'd100, 8'd105, 8'd110,
      8'd50, 8'd52, 8'd55, 8'd58, 8'd61, 8'd65, 8'd70, 8'd75,
      8'd80, 8'd85, 8'd90, 8'd95, 8'd100, 8'd105, 8'd110, 8'd120
   };

   localparam logic [7:0] MAP_PERF [256] = '{
      8'd25, 8'd28, 8'd31, 8'd34, 8'd37, 8'd40, 8'd43, 8'd46,
      8'd50, 8'd55, 8'd60, 8'd65, 8'd70, 8'd75, 8'd80, 8'd85,
      8'd28, 8'd31, 8'd34, 8'd37, 8'd40, 8'd43, 8'd46, 8'd50,
      8'd55, 8'd60, 8'd65, 8'd70, 8'd75, 8'd80, 8'd85, 8'd90,
      8'd31, 8'd34, 8'd37, 8'd40, 8'd43, 8'd46, 8'd50, 8'd55,
      8'd60, 8'd65, 8'd70, 8'd75, 8'd80, 8'd85, 8'd90, 8'd95,
      8'd34, 8'd37, 8'd40, 8'd43, 8'd46, 8'd50, 8'd55, 8'd60,
      8'd65, 8'd70, 8'd75, 8'd80, 8'd85, 8'd90, 8'd95, 8'd105,
      8'd37, 8'd40, 8'd43, 8'd46, 8'd50, 8'd55, 8'd60, 8'd65,
      8'd70, 8'd75, 8'd80, 8'd85, 8'd90, 8'd95, 8'd105, 8'd115,
      8'd40, 8'd43, 8'd46, 8'd50, 8'd55, 8'd60, 8'd65, 8'd70,
      8'd75, 8'd80, 8'd85, 8'd90, 8'd95, 8'd105, 8'd115, 8'd125,
      8'd43, 8'd46, 8'd50, 8'd55, 8'd60, 8'd65, 8'd70, 8'd75,
      8'd80, 8'd85, 8'd90, 8'd95, 8'd105, 8'd115, 8'd125, 8'd135,
      8'd46, 8'd50, 8'd55, 8'd60, 8'd65, 8'd70, 8'd75, 8'd80,
      8'd85, 8'd90, 8'd95, 8'd105, 8'd115, 8'd125, 8'd135, 8'd145,
      8'd50, 8'd55, 8'd60, 8'd65, 8'd70, 8'd75, 8'd80, 8'd85,
      8'd90, 8'd95, 8'd105, 8'd115, 8'd125, 8'd135, 8'd145, 8'd155,
      8'd55, 8'd60, 8'd65, 8'd70, 8'd75, 8'd80, 8'd85, 8'd90,
      8'd95, 8'd105, 8'd115, 8'd125, 8'd135, 8'd145, 8'd155, 8'd165,
      8'd60, 8'd65, 8'd70, 8'd75, 8'd80, 8'd85, 8'd90, 8'd95,
      8'd105, 8'd115, 8'd125, 8'd135, 8'd145, 8'd155, 8'd165, 8'd175,
      8'd65, 8'd70, 8'd75, 8'd80, 8'd85, 8'd90, 8'd95, 8'd105,
      8'd115, 8'd125, 8'd135, 8'd145, 8'd155, 8'd165, 8'd175, 8'd185,
      8'd70, 8'd75, 8'd80, 8'd85, 8'd90, 8'd95, 8'd105, 8'd115,
      8'd125, 8'd135, 8'd145, 8'd155, 8'd165, 8'd175, 8'd185, 8'd195,
      8'd75, 8'd80, 8'd85, 8'd90, 8'd95, 8'd105, 8'd115, 8'd125,
      8'd135, 8'd145, 8'd155, 8'd165, 8'd175, 8'd185, 8'd195, 8'd205,
      8'd80, 8'd85, 8'd90, 8'd95, 8'd105, 8'd115, 8'd125, 8'd135,
      8'd145, 8'd155, 8'd165, 8'd175, 8'd185, 8'd195, 8'd205, 8'd215,
      8'd85, 8'd90, 8'd95, 8'd105, 8'd115, 8'd125, 8'd135, 8'd145,
      8'd155, 8'd165, 8'd175, 8'd185, 8'd195, 8'd205, 8'd215, 8'd225
   };

   function automatic logic [7:0] map_lookup(input logic sel, input logic [7:0] idx);
      map_lookup = sel ? MAP_PERF[idx] : MAP_ECO[idx];
   endfunction

endpackage

`default_nettype wire

@@ rtl/fuel_injection_pulse_calc.sv @@
// ----------------------------------------------------------------------------
// fuel_injection_pulse_calc: engine fuel pulse and firing period calculator
// Flow: a stopped engine that does not start goes straight to the result
//   beat; otherwise the block walks the map index, lambda factor (closed
//   loop only), fuel scaling, pulse and, at nonzero speed, firing period
//   steps, with extra map index wrap steps when MAP_ENTRIES is below 256.
// One set at a time: no new set is taken until the result beat is taken.
//   The bit-serial divider: 17 steps for the lambda factor, 25 for the period.
// Reset: synchronous; engine stopped, held outputs zero, registers to defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module fuel_injection_pulse_calc
   import fipc_pkg::*;
#(
   parameter int MAP_ENTRIES = 256
)
(
   input  logic                   clock,
   input  logic                   reset,
   // input sample sets
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [31:0]            req_tdata,   // throttle_sample, speed_sample, lambda_sample
   input  logic                   req_tuser,   // cranking
   // results
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [23:0]            rsp_tdata,   // pulse_width, period_reload
   output logic [1:0]             rsp_tuser,   // timer_run, engine_running
   // configuration writes
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   // map index wraps at MAP_ENTRIES; at 256 or above it never wraps
   localparam logic [10:0] MAP_N = 11'(MAP_ENTRIES);

   fipc_cfg_type     cfg;
   fipc_div_req_type div_req;
   logic             div_busy;
   logic [DIV_Q_W-1:0] div_quo;

   fipc_state_type state_ff, state_in;

   // engine state and held outputs
   logic        running_ff, running_in;
   logic        timer_run_ff, timer_run_in;
   logic [7:0]  held_pulse_ff, held_pulse_in;
   logic [15:0] held_reload_ff, held_reload_in;

   // captured sample and working values
   logic [9:0]  thr_ff, thr_in;
   logic [12:0] rpm_ff, rpm_in;
   logic [9:0]  lam_ff, lam_in;
   logic        crank_ff, crank_in;
   logic [7:0]  idx_ff, idx_in;
   logic [16:0] fac_ff, fac_in;
   logic [24:0] v_ff, v_in;
   logic [28:0] x_ff, x_in;

   logic        req_beat;
   logic [9:0]  req_thr, req_spd, req_lam;
   logic [12:0] req_rpm;
   logic        start_ok;
   logic [16:0] lam_q;
   logic [16:0] lam_clamped;
   logic [17:0] lam_a;
   logic [33:0] lam_num;
   logic        fuel_cut;
   logic [25:0] recip_prod;

   fipc_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   fipc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_busy (div_busy),
      .div_quo  (div_quo)
   );

   assign csr_ready = 1'b1;

   // unpack the input beat
   assign req_thr  = req_tdata[9:0];
   assign req_spd  = req_tdata[19:10];
   assign req_lam  = req_tdata[29:20];
   assign req_rpm  = {req_spd, 3'b000};
   assign req_beat = req_tvalid && req_tready;
   assign start_ok = req_tuser && (req_rpm > cfg.start_rpm);

   // lambda numerator: (102300 + 100*s) * 65536 + 75190
   assign lam_a   = LAMBDA_BASE + 18'(lam_ff * LAMBDA_SCALE);
   assign lam_num = {lam_a, 16'h0000} + LAMBDA_RND;

   // clamp the lambda factor to 1/1.3 .. 1/0.7
   assign lam_q       = div_quo[16:0];
   assign lam_clamped = (lam_q < FACTOR_MIN) ? FACTOR_MIN :
                        (lam_q > FACTOR_MAX) ? FACTOR_MAX : lam_q;

   // rev limit and closed-throttle overrun both kill the fuel
   assign fuel_cut = (rpm_ff > cfg.rev_limit_rpm) ||
                     ((thr_ff < cfg.idle_throttle_limit) && (rpm_ff > cfg.overrun_cut_rpm));

   // divide (13*v >> 16) by ten through a reciprocal; exact for this range
   assign recip_prod = x_ff[28:16] * DIV10_RECIP;

   // ---------------------------------------------------------------- next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               state_in = (!running_ff && !start_ok) ? S_OUT : S_INDEX;
            end
         end
         S_INDEX: begin
            if ({3'b000, idx_ff} < MAP_N) begin
               state_in = cfg.closed_loop ? S_LDL : S_MUL;
            end
         end
         S_LDL:    state_in = S_LAMBDA;
         S_LAMBDA: begin
            if (!div_busy) begin
               state_in = S_MUL;
            end
         end
         S_MUL:    state_in = S_SCALE;
         S_SCALE:  state_in = S_PULSE;
         S_PULSE:  state_in = S_LDP;
         S_LDP:    state_in = (rpm_ff != '0) ? S_PERIOD : S_OUT;
         S_PERIOD: begin
            if (!div_busy) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
            end
         end
         default:  state_in = S_IDLE;
      endcase
   end

   // ---------------------------------------------------------------- outputs
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      div_req.load     = 1'b0;
      div_req.rem_init = {1'b0, lam_num[33:17]};
      div_req.num      = {lam_num[16:0], 17'h00000};
      div_req.den      = LAMBDA_DEN;
      div_req.steps    = LAMBDA_STEPS;
      case (state_ff)
         S_IDLE:  req_tready = 1'b1;
         S_LDL:   div_req.load = 1'b1;
         S_LDP: begin
            // skip the period when the engine shows zero speed
            div_req.load     = (rpm_ff != '0);
            div_req.rem_init = '0;
            div_req.num      = {PERIOD_CONST, 9'h000};
            div_req.den      = {5'b00000, rpm_ff};
            div_req.steps    = PERIOD_STEPS;
         end
         S_OUT:   rsp_tvalid = 1'b1;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------- datapath
   always_comb begin
      running_in     = running_ff;
      timer_run_in   = timer_run_ff;
      held_pulse_in  = held_pulse_ff;
      held_reload_in = held_reload_ff;
      thr_in   = thr_ff;
      rpm_in   = rpm_ff;
      lam_in   = lam_ff;
      crank_in = crank_ff;
      idx_in   = idx_ff;
      fac_in   = fac_ff;
      v_in     = v_ff;
      x_in     = x_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               thr_in   = req_thr;
               rpm_in   = req_rpm;
               lam_in   = req_lam;
               crank_in = req_tuser;
               idx_in   = {req_spd[9:6], req_thr[9:6]};
               if (!running_ff && !start_ok) begin
                  // stopped engine: hold outputs, timer off
                  timer_run_in = 1'b0;
               end else begin
                  timer_run_in = 1'b1;
                  // a fresh start skips the stall check
                  running_in   = running_ff ? (req_rpm >= cfg.stall_rpm) : 1'b1;
               end
            end
         end
         S_INDEX: begin
            if ({3'b000, idx_ff} >= MAP_N) begin
               idx_in = idx_ff - MAP_N[7:0];
            end else begin
               fac_in = FACTOR_ONE;
            end
         end
         S_LAMBDA: begin
            if (!div_busy) begin
               fac_in = lam_clamped;
            end
         end
         S_MUL: begin
            v_in = fuel_cut ? '0 : map_lookup(cfg.map_select, idx_ff) * fac_ff;
         end
         S_SCALE: begin
            x_in = v_ff * CRANK_MUL;
         end
         S_PULSE: begin
            if (crank_ff) begin
               held_pulse_in = (x_ff >= PULSE_SAT_X) ? PULSE_MAX : recip_prod[23:16];
            end else begin
               held_pulse_in = (v_ff > PULSE_SAT_V) ? PULSE_MAX : v_ff[23:16];
            end
         end
         S_PERIOD: begin
            if (!div_busy) begin
               // 65535 - ticks, wrapped to 16 bits
               held_reload_in = ~div_quo[15:0];
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         running_ff     <= 1'b0;
         timer_run_ff   <= 1'b0;
         held_pulse_ff  <= '0;
         held_reload_ff <= '0;
      end else begin
         state_ff       <= state_in;
         running_ff     <= running_in;
         timer_run_ff   <= timer_run_in;
         held_pulse_ff  <= held_pulse_in;
         held_reload_ff <= held_reload_in;
      end
      thr_ff   <= thr_in;
      rpm_ff   <= rpm_in;
      lam_ff   <= lam_in;
      crank_ff <= crank_in;
      idx_ff   <= idx_in;
      fac_ff   <= fac_in;
      v_ff     <= v_in;
      x_ff     <= x_in;
   end

   // pack the result beat
   assign rsp_tdata = {held_reload_ff, held_pulse_ff};
   assign rsp_tuser = {running_ff, timer_run_ff};

   // ---------------------------------------------------------------- checks
   // one item at a time: no second beat right after an accept
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_beat |=> !req_tready)
      else $error("input taken while an item is in flight");

   // the divider is quiet whenever the block waits for input
   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> !div_busy)
      else $error("divider busy while idle");

   // a held result never reports a running engine
   a_held_stopped: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> !rsp_tuser[1])
      else $error("timer off but engine reported running");

   // after the result beat the block takes input again
   a_return_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready) |=> req_tready)
      else $error("block not ready after result beat");

endmodule

`default_nettype wire

@@ rtl/fipc_csr.sv @@
// ----------------------------------------------------------------------------
// fipc_csr: configuration register bank
// Holds the seven tuning registers; writes beyond the list are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module fipc_csr
   import fipc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [CSR_INDEX_W-1:0] wr_index,
   input  logic [CSR_DATA_W-1:0]  wr_data,
   output fipc_cfg_type           cfg
);

   fipc_cfg_type cfg_ff;
   fipc_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (wr_index)
            CSR_MAP_SELECT:    cfg_in.map_select          = wr_data[0];
            CSR_CLOSED_LOOP:   cfg_in.closed_loop         = wr_data[0];
            CSR_REV_LIMIT:     cfg_in.rev_limit_rpm       = wr_data;
            CSR_OVERRUN_CUT:   cfg_in.overrun_cut_rpm     = wr_data;
            CSR_IDLE_THROTTLE: cfg_in.idle_throttle_limit = wr_data[9:0];
            CSR_START_RPM:     cfg_in.start_rpm           = wr_data;
            CSR_STALL_RPM:     cfg_in.stall_rpm           = wr_data;
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.map_select          <= 1'b0;
         cfg_ff.closed_loop         <= 1'b0;
         cfg_ff.rev_limit_rpm       <= REV_LIMIT_RST;
         cfg_ff.overrun_cut_rpm     <= OVERRUN_CUT_RST;
         cfg_ff.idle_throttle_limit <= IDLE_THROTTLE_RST;
         cfg_ff.start_rpm           <= START_RPM_RST;
         cfg_ff.stall_rpm           <= STALL_RPM_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

@@ rtl/fipc_div.sv @@
// ----------------------------------------------------------------------------
// fipc_div: bit-serial restoring divider
// Shifts the numerator in one bit per cycle while busy and yields one quotient bit.
// ----------------------------------------------------------------------------
`default_nettype none

module fipc_div
   import fipc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  fipc_div_req_type     div_req,
   output logic                 div_busy,
   output logic [DIV_Q_W-1:0]   div_quo
);

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] num_ff, num_in;
   logic [DIV_DEN_W-1:0] den_ff, den_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [DIV_Q_W-1:0]   quo_ff, quo_in;
   logic                 busy_ff, busy_in;

   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;

   assign trial = {rem_ff, num_ff[DIV_NUM_W-1]};
   assign diff  = trial - {1'b0, den_ff};
   assign fits  = (trial >= {1'b0, den_ff});

   always_comb begin
      rem_in  = rem_ff;
      num_in  = num_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      busy_in = busy_ff;
      if (div_req.load) begin
         rem_in  = div_req.rem_init;
         num_in  = div_req.num;
         den_in  = div_req.den;
         cnt_in  = div_req.steps;
         quo_in  = '0;
         busy_in = (div_req.steps != '0);
      end else if (busy_ff) begin
         // subtract when the divisor fits, shift the next numerator bit in
         rem_in  = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
         num_in  = {num_ff[DIV_NUM_W-2:0], 1'b0};
         quo_in  = {quo_ff[DIV_Q_W-2:0], fits};
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != DIV_CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      num_ff <= num_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign div_busy = busy_ff;
   assign div_quo  = quo_ff;

endmodule

`default_nettype wire

@@ test/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: fuel injection pulse calculator testbench
// A stimulus table of sensor sets runs first. Random drive cycles follow
// under six register settings, with idle gaps on the input side, stalls on
// the result side, and one long result-side hold-off. An in-order scoreboard
// checks every beat against a cycle-free model or a hand-written result.
// ----------------------------------------------------------------------------

module tb
   import fipc_pkg::*;
;

   // Stray register index: the block must ignore writes to it
   localparam logic [CSR_INDEX_W-1:0] CSR_NO_REG = 3'd7;

   // Fixed-point figures of the fuel calculation
   localparam longint unsigned AFR_OFFSET  = 102300; // AFR 10.0 in lambda units
   localparam longint unsigned AFR_SLOPE   = 100;
   localparam longint unsigned AFR_ROUND   = 75190;  // half of the divisor
   localparam longint unsigned STOICH_DEN  = 150381; // 14.7 in lambda units
   localparam int unsigned     UNITY_GAIN  = 65536;  // 1.0 in Q1.16
   localparam int unsigned     GAIN_FLOOR  = 50412;  // 1/1.3
   localparam int unsigned     GAIN_CEIL   = 93623;  // 1/0.7
   localparam int unsigned     PERIOD_NUM  = 18750000;
   localparam int unsigned     PULSE_CEIL  = 255;

   localparam int unsigned RANDOM_PER_PHASE = 150;
   localparam int unsigned PHASE_COUNT      = 6;
   localparam int unsigned HOLD_OFF_CYCLES  = 600;
   localparam int unsigned TAIL_CYCLES      = 70;  // longest latency plus margin

   typedef struct packed {
      logic [9:0] throttle;
      logic [9:0] speed;
      logic [9:0] lambda;
      logic       cranking;
   } sensor_set_type;

   typedef struct packed {
      logic [7:0]  pulse_width;
      logic [15:0] period_reload;
      logic        timer_run;
      logic        engine_running;
   } injection_out_type;

   typedef struct {
      sensor_set_type    sample;
      bit                typed;   // want holds a hand-written result
      injection_out_type want;
   } bench_row_type;

   // ------------------------------------------------------------------------
   // DUT hookup
   // ------------------------------------------------------------------------
   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [31:0]            req_tdata;   // throttle [9:0], speed [19:10], lambda [29:20]
   logic                   req_tuser;   // cranking
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [23:0]            rsp_tdata;   // pulse_width [7:0], period_reload [23:8]
   logic [1:0]             rsp_tuser;   // timer_run [0], engine_running [1]
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   fuel_injection_pulse_calc i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock <= ~clock;

   // ------------------------------------------------------------------------
   // Calculator model: register copy, engine state and held outputs
   // ------------------------------------------------------------------------
   fipc_cfg_type      cfg;
   bit                engine_on;
   logic [7:0]        held_pw;
   logic [15:0]       held_reload;
   injection_out_type pending_pulses [$];
   int unsigned       mismatch_count;

   // Knobs for the two stream sides; written with NBAs only
   int unsigned    sender_idle_pct;
   int unsigned    rsp_stall_pct;
   bit             hold_toggle;

   function automatic void reset_injection_model();
      cfg.map_select          = 1'b0;
      cfg.closed_loop         = 1'b0;
      cfg.rev_limit_rpm       = 13'd6500;
      cfg.overrun_cut_rpm     = 13'd1800;
      cfg.idle_throttle_limit = 10'd20;
      cfg.start_rpm           = 13'd300;
      cfg.stall_rpm           = 13'd400;
      engine_on   = 1'b0;
      held_pw     = '0;
      held_reload = '0;
   endfunction

   // Both maps are constant along anti-diagonals: the entry at row r,
   // column c depends on r + c only, so one curve per map covers it.
   function automatic int unsigned fuel_curve(logic perf, int unsigned k);
      if (!perf) begin
         if (k <= 16) return 20 + 2 * k;
         if (k <= 19) return 55 + 3 * (k - 17);
         if (k <= 29) return 65 + 5 * (k - 20);
         return 120;
      end
      if (k <= 7)  return 25 + 3 * k;
      if (k <= 17) return 50 + 5 * (k - 8);
      return 105 + 10 * (k - 18);
   endfunction

   // Advance the model by one sensor set and return the result it gives
   function automatic injection_out_type compute_injection(sensor_set_type s);
      int unsigned       rpm, base, gain, ticks;
      longint unsigned   afr_num, fuel;
      injection_out_type r;
      rpm = s.speed * 8;
      r   = '0;
      if (!engine_on) begin
         if (s.cranking && rpm > cfg.start_rpm) begin
            engine_on = 1'b1;
         end else begin
            // stopped: hold the last outputs, timer off
            r.pulse_width   = held_pw;
            r.period_reload = held_reload;
            return r;
         end
      end else if (rpm < cfg.stall_rpm) begin
         engine_on = 1'b0;   // stall: this step still fires
      end

      base = fuel_curve(cfg.map_select, s.speed[9:6] + s.throttle[9:6]);
      gain = UNITY_GAIN;
      if (cfg.closed_loop) begin
         afr_num = ((AFR_OFFSET + AFR_SLOPE * s.lambda) << 16) + AFR_ROUND;
         gain    = int'(afr_num / STOICH_DEN);
         if (gain < GAIN_FLOOR) gain = GAIN_FLOOR;
         if (gain > GAIN_CEIL)  gain = GAIN_CEIL;
      end

      fuel = longint'(base) * gain;
      if (rpm > cfg.rev_limit_rpm) fuel = 0;
      if (s.throttle < cfg.idle_throttle_limit && rpm > cfg.overrun_cut_rpm) fuel = 0;
      if (s.cranking) fuel = fuel * 13 / 10;
      r.pulse_width = (fuel > (longint'(PULSE_CEIL) << 16)) ? 8'd255 : fuel[23:16];

      // zero speed keeps the old reload
      if (rpm != 0) begin
         ticks       = PERIOD_NUM / rpm;
         held_reload = 16'hFFFF - ticks[15:0];
      end
      held_pw = r.pulse_width;

      r.period_reload  = held_reload;
      r.timer_run      = 1'b1;
      r.engine_running = engine_on;
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus table: reset state, field extremes, every cut and every
   // start/stall transition under the reset register values
   // ------------------------------------------------------------------------
   localparam injection_out_type HELD_AT_RESET = '0;
   localparam injection_out_type MAX_START     = '{8'd0, 16'd63244, 1'b1, 1'b1};

   bench_row_type bench_rows [0:20] = '{
      '{'{10'd0,    10'd0,    10'd0,    1'b0}, 1'b1, HELD_AT_RESET}, // all low, stopped
      '{'{10'd1023, 10'd1023, 10'd1023, 1'b0}, 1'b1, HELD_AT_RESET}, // all high, no crank
      '{'{10'd500,  10'd37,   10'd500,  1'b1}, 1'b1, HELD_AT_RESET}, // crank just under start
      '{'{10'd1023, 10'd1023, 10'd1023, 1'b1}, 1'b1, MAX_START},     // start at rev cut
      '{'{10'd1023, 10'd812,  10'd0,    1'b0}, 1'b0, '0},            // just under rev limit
      '{'{10'd0,    10'd1023, 10'd0,    1'b0}, 1'b0, '0},            // rev cut and overrun
      '{'{10'd19,   10'd226,  10'd300,  1'b0}, 1'b0, '0},            // overrun cut
      '{'{10'd20,   10'd226,  10'd300,  1'b0}, 1'b0, '0},            // throttle at idle limit
      '{'{10'd19,   10'd225,  10'd300,  1'b0}, 1'b0, '0},            // rpm at overrun limit
      '{'{10'd600,  10'd400,  10'd700,  1'b1}, 1'b0, '0},            // cranking while running
      '{'{10'd64,   10'd64,   10'd512,  1'b0}, 1'b0, '0},
      '{'{10'd960,  10'd960,  10'd512,  1'b0}, 1'b0, '0},            // top map corner
      '{'{10'd300,  10'd50,   10'd100,  1'b0}, 1'b0, '0},            // rpm at stall limit
      '{'{10'd300,  10'd49,   10'd100,  1'b0}, 1'b0, '0},            // stall
      '{'{10'd300,  10'd49,   10'd100,  1'b0}, 1'b0, '0},            // stopped, held
      '{'{10'd300,  10'd38,   10'd100,  1'b1}, 1'b0, '0},            // restart
      '{'{10'd300,  10'd0,    10'd100,  1'b0}, 1'b0, '0},            // zero speed stall
      '{'{10'd300,  10'd0,    10'd100,  1'b1}, 1'b0, '0},            // crank at zero rpm
      '{'{10'd0,    10'd100,  10'd1023, 1'b1}, 1'b0, '0},
      '{'{10'd63,   10'd63,   10'd64,   1'b0}, 1'b0, '0},
      '{'{10'd1023, 10'd511,  10'd0,    1'b0}, 1'b0, '0}
   };

   // ------------------------------------------------------------------------
   // Mismatch reporting and result checking
   // ------------------------------------------------------------------------
   task automatic log_mismatch(input string what);
      mismatch_count++;
      $display("%0t ns: mismatch: %s", $time, what);
   endtask

   task automatic check_beat();
      injection_out_type want;
      if (pending_pulses.size() == 0) begin
         log_mismatch("result beat with nothing pending");
         return;
      end
      want = pending_pulses.pop_front();
      if (rsp_tdata[7:0] !== want.pulse_width)
         log_mismatch($sformatf("pulse_width %0d, want %0d", rsp_tdata[7:0], want.pulse_width));
      if (rsp_tdata[23:8] !== want.period_reload)
         log_mismatch($sformatf("period_reload %0d, want %0d",
                                rsp_tdata[23:8], want.period_reload));
      if (rsp_tuser[0] !== want.timer_run)
         log_mismatch($sformatf("timer_run %b, want %b", rsp_tuser[0], want.timer_run));
      if (rsp_tuser[1] !== want.engine_running)
         log_mismatch($sformatf("engine_running %b, want %b",
                                rsp_tuser[1], want.engine_running));
   endtask

   // ------------------------------------------------------------------------
   // Input side
   // ------------------------------------------------------------------------
   // Offer one sensor set, idling at random first; valid stays high after the
   // accepting edge so back-to-back beats never toggle it within one step.
   task automatic offer_sample(input sensor_set_type s, input bit typed,
                               input injection_out_type want);
      injection_out_type got;
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {2'b00, s.lambda, s.speed, s.throttle};
      req_tuser  <= s.cranking;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      got = compute_injection(s);
      pending_pulses.push_back(typed ? want : got);
   endtask

   // Register write; valid is left high for the caller to drop
   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [12:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_MAP_SELECT:    cfg.map_select          = data[0];
         CSR_CLOSED_LOOP:   cfg.closed_loop         = data[0];
         CSR_REV_LIMIT:     cfg.rev_limit_rpm       = data;
         CSR_OVERRUN_CUT:   cfg.overrun_cut_rpm     = data;
         CSR_IDLE_THROTTLE: cfg.idle_throttle_limit = data[9:0];
         CSR_START_RPM:     cfg.start_rpm           = data;
         CSR_STALL_RPM:     cfg.stall_rpm           = data;
         default: ;
      endcase
   endtask

   task automatic load_settings(input logic [12:0] map_sel, closed, rev, overrun,
                                input logic [12:0] idle_thr, start, stall,
                                input bit stray);
      csr_write(CSR_MAP_SELECT,    map_sel);
      csr_write(CSR_CLOSED_LOOP,   closed);
      csr_write(CSR_REV_LIMIT,     rev);
      csr_write(CSR_OVERRUN_CUT,   overrun);
      csr_write(CSR_IDLE_THROTTLE, idle_thr);
      csr_write(CSR_START_RPM,     start);
      csr_write(CSR_STALL_RPM,     stall);
      if (stray) csr_write(CSR_NO_REG, 13'($urandom_range(8191)));
      csr_valid <= 1'b0;
   endtask

   // Drop valid and wait until every pending result has come back
   task automatic await_quiet();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_pulses.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Speed code a few steps either side of an rpm threshold
   function automatic logic [9:0] near_code(input int unsigned rpm_mark);
      int code;
      code = int'(rpm_mark / 8) + int'($urandom_range(6)) - 3;
      if (code < 0)    code = 0;
      if (code > 1023) code = 1023;
      return code[9:0];
   endfunction

   // Drive cycles: crank a stopped engine near the start threshold, then
   // roam the map with visits to the stall, rev and overrun edges. One in
   // ten sets is plain noise.
   function automatic sensor_set_type draw_sample();
      sensor_set_type s;
      s.throttle = 10'($urandom_range(1023));
      s.speed    = 10'($urandom_range(1023));
      s.lambda   = 10'($urandom_range(1023));
      s.cranking = 1'($urandom_range(1));
      if ($urandom_range(9) == 0) return s;
      if (!engine_on) begin
         s.cranking = 1'b1;
         s.speed    = near_code(cfg.start_rpm + 8 * $urandom_range(4));
         return s;
      end
      s.cranking = ($urandom_range(19) == 0);
      case ($urandom_range(9))
         0: s.speed = near_code(cfg.stall_rpm);
         1: s.speed = near_code(cfg.rev_limit_rpm);
         2: begin
            s.speed    = near_code(cfg.overrun_cut_rpm);
            s.throttle = near_code(8 * cfg.idle_throttle_limit);
         end
         default: ;
      endcase
      return s;
   endfunction

   // ------------------------------------------------------------------------
   // Result side: check each beat, stall at random, and honor a long
   // hold-off whenever the stimulus flips hold_toggle
   // ------------------------------------------------------------------------
   initial begin : rsp_side
      int unsigned hold_left;
      bit          seen_toggle;
      hold_left   = 0;
      seen_toggle = 1'b0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) check_beat();
         if (hold_toggle != seen_toggle) begin
            seen_toggle = hold_toggle;
            hold_left   = HOLD_OFF_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   initial begin : stimulus
      int unsigned phase_no;
      int unsigned n;
      reset           <= 1'b1;
      req_tvalid      <= 1'b0;
      req_tdata       <= '0;
      req_tuser       <= 1'b0;
      csr_valid       <= 1'b0;
      csr_index       <= '0;
      csr_data        <= '0;
      sender_idle_pct <= 0;
      rsp_stall_pct   <= 0;
      hold_toggle     <= 1'b0;
      mismatch_count   = 0;
      reset_injection_model();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // table first, under the reset register values
      foreach (bench_rows[i])
         offer_sample(bench_rows[i].sample, bench_rows[i].typed, bench_rows[i].want);

      for (phase_no = 0; phase_no < PHASE_COUNT; phase_no++) begin
         await_quiet();
         // rotate the idle pattern: none, sender, receiver, both
         case (phase_no % 4)
            0: begin sender_idle_pct <= 0;  rsp_stall_pct <= 0;  end
            1: begin sender_idle_pct <= 63; rsp_stall_pct <= 0;  end
            2: begin sender_idle_pct <= 0;  rsp_stall_pct <= 63; end
            default: begin sender_idle_pct <= 28; rsp_stall_pct <= 28; end
         endcase
         case (phase_no)
            // junk upper bits on the map select register; stray index write
            0: load_settings(13'h1FFF, 13'd1, 13'd6500, 13'd1800, 13'd20, 13'd300, 13'd400, 1);
            // extremes: no rev cut, overrun everywhere, instant start, no stall
            1: load_settings(13'd0, 13'd1, 13'h1FFF, 13'd0, 13'd1023, 13'd0, 13'd0, 0);
            // extremes: fuel cut at any nonzero speed, every running step stalls
            2: load_settings(13'd1, 13'h1FFE, 13'd0, 13'h1FFF, 13'd0, 13'd0, 13'h1FFF, 0);
            3: load_settings(13'd0, 13'd1, 13'd4000, 13'd2500, 13'd100, 13'd200, 13'd300, 1);
            4: load_settings(13'($urandom_range(8191)), 13'($urandom_range(8191)),
                             13'($urandom_range(8191)), 13'($urandom_range(8191)),
                             13'($urandom_range(1023)), 13'($urandom_range(1200)),
                             13'($urandom_range(1200)), 0);
            default: load_settings(13'd1, 13'd1, 13'd7000, 13'd1000, 13'd60, 13'd500,
                                   13'd350, 0);
         endcase
         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            // hold off the receiver while sets keep coming, so input stalls
            if (phase_no == 4 && n == 0) hold_toggle <= ~hold_toggle;
            offer_sample(draw_sample(), 1'b0, '0);
         end
      end

      await_quiet();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_pulses.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   // Hard stop well past the slowest correct run
   initial begin : watchdog
      #2_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
